// File: hdl/par_pkg.sv
package par_pkg;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
  } result_t;

  localparam int unsigned CORD_W = 34;
  localparam int unsigned ANG_W  = 33;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     neg;
  } cord_t;

  typedef struct packed {
    point_t pt;
    cord_t  cd;
  } cell_t;

  localparam int unsigned CFG_W     = 18;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [CORD_W-1:0] COS_GAIN = 34'sd652032874;

  localparam logic [15:0] RECIP_INT   = 16'd46603;
  localparam logic [4:0]  RESID_MUL   = 5'd17;
  localparam logic [4:0]  RESID_BIAS  = 5'd22;
  localparam logic [5:0]  TURN_DIV    = 6'd45;
  localparam logic [22:0] RECIP_FRAC  = 23'd5965232;
  localparam int unsigned RECIP_SHIFT = 28;

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// File: hdl/par_phase.sv
module par_phase (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [2:0]                         rdy_i,
  input  logic                               vld_i,
  input  par_pkg::point_t                    pt_i,
  input  logic signed [par_pkg::CFG_W-1:0]   angle_i,
  output logic [2:0]                         vld_o,
  output par_pkg::cell_t                     cell_o
);

  logic [2:0] vld_q;

  logic [17:0] mag;
  logic        a_sgn_q, b_sgn_q;
  logic [33:0] a_qhi_q, b_qhi_q;
  logic [21:0] a_res_q, b_res_q;
  logic [16:0] b_quo_q;
  logic [44:0] prod;
  par_pkg::point_t a_pt_q, b_pt_q;

  logic [21:0] rem;
  logic [33:0] quo;
  logic [31:0] ph, ph_f;
  logic        fold;
  par_pkg::cell_t c_d, c_q;

  assign mag  = angle_i[17] ? 18'(-angle_i) : 18'(angle_i);
  assign prod = 45'(a_res_q) * 45'(par_pkg::RECIP_FRAC);

  always_comb begin
    rem  = b_res_q - 22'(b_quo_q) * 22'(par_pkg::TURN_DIV);
    quo  = b_qhi_q + 34'(b_quo_q) + 34'(rem >= 22'(par_pkg::TURN_DIV));
    ph   = b_sgn_q ? 32'(-quo[31:0]) : quo[31:0];
    fold = ph[31] ^ ph[30];
    ph_f = {ph[31] ^ fold, ph[30:0]};
    c_d.pt    = b_pt_q;
    c_d.cd.x  = par_pkg::COS_GAIN;
    c_d.cd.y  = '0;
    c_d.cd.z  = 33'($signed(ph_f));
    c_d.cd.neg = fold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy_i[0]) vld_q[0] <= vld_i;
      if (rdy_i[1]) vld_q[1] <= vld_q[0];
      if (rdy_i[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_i[0] && vld_i) begin
      a_pt_q  <= pt_i;
      a_sgn_q <= angle_i[17];
      a_qhi_q <= 34'(mag) * 34'(par_pkg::RECIP_INT);
      a_res_q <= 22'(mag) * 22'(par_pkg::RESID_MUL) + 22'(par_pkg::RESID_BIAS);
    end
    if (rdy_i[1] && vld_q[0]) begin
      b_pt_q  <= a_pt_q;
      b_sgn_q <= a_sgn_q;
      b_qhi_q <= a_qhi_q;
      b_res_q <= a_res_q;
      b_quo_q <= prod[44:par_pkg::RECIP_SHIFT];
    end
    if (rdy_i[2] && vld_q[1]) begin
      c_q <= c_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = c_q;

endmodule

// File: hdl/par_cell.sv
module par_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rdy_i,
  input  logic           vld_i,
  input  par_pkg::cell_t cell_i,
  output logic           vld_o,
  output par_pkg::cell_t cell_o
);

  logic                               vld_q;
  par_pkg::cell_t                     cell_d, cell_q;
  logic signed [par_pkg::CORD_W-1:0]  xs, ys;
  logic signed [par_pkg::ANG_W-1:0]   at;

  assign xs = cell_i.cd.x >>> SHIFT;
  assign ys = cell_i.cd.y >>> SHIFT;
  assign at = $signed({1'b0, par_pkg::ATAN_TURN[SHIFT]});

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.cd.z[par_pkg::ANG_W-1]) begin
      cell_d.cd.x = cell_i.cd.x - ys;
      cell_d.cd.y = cell_i.cd.y + xs;
      cell_d.cd.z = cell_i.cd.z - at;
    end else begin
      cell_d.cd.x = cell_i.cd.x + ys;
      cell_d.cd.y = cell_i.cd.y - xs;
      cell_d.cd.z = cell_i.cd.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_i && vld_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

// File: hdl/par_rot.sv
module par_rot (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        rdy_i,
  input  logic                              vld_i,
  input  par_pkg::cell_t                    cell_i,
  input  logic [par_pkg::AXIS_W-1:0]        axis_i,
  output logic [1:0]                        vld_o,
  output par_pkg::result_t                  res_o
);

  logic [1:0]                        vld_q;
  logic signed [par_pkg::CORD_W-1:0] cv, sv;
  logic signed [31:0]                ua, ub;
  logic signed [65:0]                ac_q, bs_q, as_q, bc_q;
  par_pkg::point_t                   pt_q;
  logic signed [66:0]                sum_a, sum_b;
  logic signed [31:0]                ra, rb;
  par_pkg::result_t                  res_d, res_q;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] acc);
    logic signed [66:0] rnd;
    logic signed [36:0] sh;
    rnd = acc + 67'sd536870912;
    sh  = rnd[66:30];
    if (sh > 37'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (sh < -37'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = sh[31:0];
    end
  endfunction

  always_comb begin
    cv = cell_i.cd.neg ? -cell_i.cd.x : cell_i.cd.x;
    sv = cell_i.cd.neg ? -cell_i.cd.y : cell_i.cd.y;
    case (axis_i)
      par_pkg::AXIS_X: begin
        ua = cell_i.pt.y_in;
        ub = cell_i.pt.z_in;
      end
      par_pkg::AXIS_Y: begin
        ua = cell_i.pt.z_in;
        ub = cell_i.pt.x_in;
      end
      default: begin
        ua = cell_i.pt.x_in;
        ub = cell_i.pt.y_in;
      end
    endcase
  end

  always_comb begin
    sum_a = 67'(ac_q) - 67'(bs_q);
    sum_b = 67'(as_q) + 67'(bc_q);
    ra    = sat32(sum_a);
    rb    = sat32(sum_b);
    res_d.x_out = pt_q.x_in;
    res_d.y_out = pt_q.y_in;
    res_d.z_out = pt_q.z_in;
    case (axis_i)
      par_pkg::AXIS_X: begin
        res_d.y_out = ra;
        res_d.z_out = rb;
      end
      par_pkg::AXIS_Y: begin
        res_d.z_out = ra;
        res_d.x_out = rb;
      end
      par_pkg::AXIS_Z: begin
        res_d.x_out = ra;
        res_d.y_out = rb;
      end
      default: begin
        res_d.x_out = pt_q.x_in;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy_i[0]) vld_q[0] <= vld_i;
      if (rdy_i[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_i[0] && vld_i) begin
      pt_q <= cell_i.pt;
      ac_q <= 66'(ua) * 66'(cv);
      bs_q <= 66'(ub) * 66'(sv);
      as_q <= 66'(ua) * 66'(sv);
      bc_q <= 66'(ub) * 66'(cv);
    end
    if (rdy_i[1] && vld_q[0]) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

// File: hdl/point_axis_rotation_unit.sv
// Path: each accepted input beat passes the phase stages, the cells and the rotate stages.
// Throughput: one beat per cycle unless stalled; the sine/cosine chain, one cell per stage,
// travels with each point, followed by one multiply and one round/saturate stage.
// Every stage fills bubbles on its own, so input stalls only when the whole pipe is full.
// Reset: asynchronous, active low; clears all valid bits, axis to x, angle to zero.
module point_axis_rotation_unit #(
  parameter int unsigned ANGLE_STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  par_pkg::point_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output par_pkg::result_t                     out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [par_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [par_pkg::CFG_W-1:0]            cfg_wdata_i
);

  localparam int unsigned NS = ANGLE_STAGES + 5;
  localparam int unsigned CB = 3;

  logic [par_pkg::AXIS_W-1:0]        axis_q;
  logic signed [par_pkg::CFG_W-1:0]  angle_q;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic           cell_v [ANGLE_STAGES+1];
  par_pkg::cell_t cell_d [ANGLE_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= par_pkg::AXIS_X;
      angle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        par_pkg::CFG_AXIS:  axis_q  <= cfg_wdata_i[par_pkg::AXIS_W-1:0];
        par_pkg::CFG_ANGLE: angle_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  par_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rdy_i   (rdy[2:0]),
    .vld_i   (in_valid_i),
    .pt_i    (in_data_i),
    .angle_i (angle_q),
    .vld_o   (vld[2:0]),
    .cell_o  (cell_d[0])
  );

  assign cell_v[0] = vld[2];

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
    par_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rdy_i  (rdy[CB+k]),
      .vld_i  (cell_v[k]),
      .cell_i (cell_d[k]),
      .vld_o  (cell_v[k+1]),
      .cell_o (cell_d[k+1])
    );
    assign vld[CB+k] = cell_v[k+1];
  end

  par_rot u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rdy_i  (rdy[NS-1:NS-2]),
    .vld_i  (cell_v[ANGLE_STAGES]),
    .cell_i (cell_d[ANGLE_STAGES]),
    .axis_i (axis_q),
    .vld_o  (vld[NS-1:NS-2]),
    .res_o  (out_data_o)
  );

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld[NS-1];

endmodule

// File: hdl/par_checker.sv
module par_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input par_pkg::result_t              out_data_o
);

  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output beat valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side can drain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> out_valid_o)
    else $error("pipe drained output while input was held off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

endmodule

bind point_axis_rotation_unit par_checker u_par_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
